FILE: sv/utf8d_pkg.sv
package utf8d_pkg;

   localparam int ByteWidth = 8;
   localparam int CpWidth = 21;
   localparam int PendWidth = 2;
   localparam int QueueDepth = 4;
   localparam int QPtrWidth = $clog2(QueueDepth);
   localparam int QCntWidth = $clog2(QueueDepth + 1);

   localparam logic [3:0] LeadFour = 4'hF;
   localparam logic [3:0] LeadThree = 4'hE;
   localparam logic [3:0] LeadTwoHi = 4'hD;
   localparam logic [3:0] LeadTwoLo = 4'hC;
   localparam logic [1:0] ContTag = 2'b10;

   localparam logic [PendWidth-1:0] PendNone = 2'd0;
   localparam logic [PendWidth-1:0] PendOne = 2'd1;
   localparam logic [PendWidth-1:0] PendTwo = 2'd2;
   localparam logic [PendWidth-1:0] PendThree = 2'd3;

   typedef struct packed {
      logic [CpWidth-1:0] codepoint;
      logic               malformed;
   } rsp_type;

   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } entry_type;

endpackage

FILE: sv/utf8d_front.sv
module utf8d_front
   import utf8d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [ByteWidth-1:0] text_byte,
   input  logic                 end_of_text,
   output logic                 entry_valid,
   output entry_type            entry
);

   logic [PendWidth-1:0] pend_ff, pend_in;
   logic [CpWidth-1:0]   partial_ff, partial_in;
   logic [ByteWidth-1:0] lead_ff, lead_in;
   rsp_type              res [2];
   logic [1:0]           n;
   logic                 fresh;
   logic [CpWidth-1:0]   byte_cp;

   assign byte_cp = {{(CpWidth - ByteWidth){1'b0}}, text_byte};

   always_comb begin
      pend_in = pend_ff;
      partial_in = partial_ff;
      lead_in = lead_ff;
      res[0] = '0;
      res[1] = '0;
      n = 2'd0;
      fresh = 1'b1;
      if (pend_ff != PendNone) begin
         if (text_byte[7:6] == ContTag) begin
            partial_in = {partial_ff[CpWidth-7:0], text_byte[5:0]};
            pend_in = pend_ff - PendOne;
            if (pend_in == PendNone) begin
               res[0] = '{codepoint: partial_in, malformed: 1'b0};
               n = 2'd1;
            end
            fresh = 1'b0;
         end else begin
            res[0] = '{codepoint: {{(CpWidth - ByteWidth){1'b0}}, lead_ff}, malformed: 1'b1};
            n = 2'd1;
            pend_in = PendNone;
         end
      end
      if (fresh) begin
         unique case (text_byte[7:4])
            LeadFour: begin
               partial_in = {{(CpWidth - 3){1'b0}}, text_byte[2:0]};
               pend_in = PendThree;
               lead_in = text_byte;
            end
            LeadThree: begin
               partial_in = {{(CpWidth - 4){1'b0}}, text_byte[3:0]};
               pend_in = PendTwo;
               lead_in = text_byte;
            end
            LeadTwoHi, LeadTwoLo: begin
               partial_in = {{(CpWidth - 5){1'b0}}, text_byte[4:0]};
               pend_in = PendOne;
               lead_in = text_byte;
            end
            default: begin
               res[n[0]] = '{codepoint: byte_cp, malformed: 1'b0};
               n = n + 2'd1;
            end
         endcase
      end
      if (end_of_text && pend_in != PendNone) begin
         res[n[0]] = '{codepoint: {{(CpWidth - ByteWidth){1'b0}}, lead_in}, malformed: 1'b1};
         n = n + 2'd1;
         pend_in = PendNone;
      end
   end

   assign entry_valid = accept && (n != 2'd0);
   assign entry = '{two: n[1], first: res[0], second: res[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PendNone;
         partial_ff <= '0;
         lead_ff <= '0;
      end else if (accept) begin
         pend_ff <= pend_in;
         partial_ff <= partial_in;
         lead_ff <= lead_in;
      end
   end

endmodule

FILE: sv/utf8d_back.sv
module utf8d_back
   import utf8d_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      entry_valid,
   input  entry_type entry,
   output logic      full,
   output logic      empty,
   input  logic      pop,
   output rsp_type   rsp,
   output logic      run_last
);

   entry_type              mem [QueueDepth];
   logic [QPtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCntWidth-1:0]   count_ff, count_in;
   logic                   half_ff;
   logic                   wr_en, rd_done, pop_ok;
   entry_type              head;

   assign full = (count_ff == QCntWidth'(QueueDepth));
   assign empty = (count_ff == '0);
   assign wr_en = entry_valid && !full;
   assign head = mem[rd_ptr_ff];
   assign pop_ok = pop && !empty;
   assign rd_done = pop_ok && (!head.two || half_ff);

   always_comb begin
      rsp = half_ff ? head.second : head.first;
      run_last = half_ff || !head.two;
   end

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_done) begin
         count_in = count_ff + QCntWidth'(1);
      end else if (!wr_en && rd_done) begin
         count_in = count_ff - QCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         half_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + QPtrWidth'(1);
         end
         if (rd_done) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrWidth'(1);
            half_ff <= 1'b0;
         end else if (pop_ok) begin
            half_ff <= 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntWidth'(QueueDepth))
      else $error("queue count above depth");

   a_half_head: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (!empty && head.two))
      else $error("second half shown without a two-result head");

   a_split_pop: assert property (@(posedge clock) disable iff (reset)
      (pop_ok && head.two && !half_ff) |=> half_ff)
      else $error("first of two results popped without advancing half");

   a_empty_clear: assert property (@(posedge clock) disable iff (reset)
      empty |-> !half_ff)
      else $error("half flag set on empty queue");

endmodule

FILE: sv/utf8_codepoint_decoder_top.sv
// UTF-8 codepoint decoder.
// Input side: drive req_text_byte and req_end_of_text with push high; the
// byte is taken on a rising edge where push is high and full is low. One
// byte can be taken every cycle while full stays low.
// Result side: while empty is low, rsp_codepoint, rsp_malformed and
// rsp_run_last show the oldest result; pop high on an edge takes it.
// A byte gives zero, one or two results; rsp_run_last marks the last result
// of each byte. A result enters the queue on the edge that takes its byte
// and shows once it is at the head. Sustained rate is one byte per cycle
// while each byte gives at most one result and pop stays high; a byte with
// two results needs two pops, set by the single result port at the head.
// A four-entry queue of per-byte entries sits between the decode front and
// the output back, so when the receiver stalls, bytes keep being taken until
// the queue fills and full rises.
// Reset clears the pending sequence and empties the queue.
module utf8_codepoint_decoder_top
   import utf8d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [ByteWidth-1:0] req_text_byte,
   input  logic                 req_end_of_text,
   output logic                 empty,
   input  logic                 pop,
   output logic [CpWidth-1:0]   rsp_codepoint,
   output logic                 rsp_malformed,
   output logic                 rsp_run_last
);

   logic      accept;
   logic      entry_valid;
   entry_type entry;
   rsp_type   rsp;

   assign accept = push && !full;

   utf8d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .entry_valid (entry_valid),
      .entry       (entry)
   );

   utf8d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (entry_valid),
      .entry       (entry),
      .full        (full),
      .empty       (empty),
      .pop         (pop),
      .rsp         (rsp),
      .run_last    (rsp_run_last)
   );

   assign rsp_codepoint = rsp.codepoint;
   assign rsp_malformed = rsp.malformed;

endmodule
